// ----- hw/rtl/gtsp_pkg.sv -----
// Shared types and constants for the packet tag stream parser.
// No dependencies; used by gif_tag_stream_parser_core.

package gtsp_pkg;

   typedef enum logic [1:0] {
      PH_TAG   = 2'd0,
      PH_DATA  = 2'd1,
      PH_DRAIN = 2'd2
   } phase_type;

   typedef logic [1:0] mode_type;

   localparam mode_type MODE_LIST  = 2'd0;
   localparam mode_type MODE_ONE   = 2'd1;
   localparam mode_type MODE_IMAGE = 2'd2;
   localparam mode_type MODE_SKIP  = 2'd3;

   localparam int WORD_W  = 64;
   localparam int LEFT_W  = 21;
   localparam int NLOOP_W = 15;
   localparam int NREG_W  = 6;
   localparam int LIST_W  = 36;
   localparam int ADDR_W  = 7;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_IMAGE = 1'b1;

endpackage

// ----- hw/rtl/gif_tag_stream_parser_core.sv -----
// Top level of the packet tag stream parser: input register, section state
// and a result register that steps through the writes of one word.
// Depends on gtsp_pkg.
//
//   channel | direction | fields
//   req     | in        | req_word[63:0], req_packet_end
//   rsp     | out       | rsp_kind, rsp_reg_addr[6:0], rsp_payload[63:0], rsp_last
//
// A word is taken every cycle while the result register is free. Tag words,
// ignored words and words of a skipping section give no result. A data word
// gives one result, or min(register count, MAX_LIST_REGS) results in list mode,
// sent one per cycle from the result register while rsp_ready is high; that
// count sets the rate. One input word waits in the input register while results stall.
// Synchronous reset returns the parser to expecting a tag with no output.

module gif_tag_stream_parser_core #(
   parameter int MAX_LIST_REGS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_word,
   input  logic        req_packet_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [6:0]  rsp_reg_addr,
   output logic [63:0] rsp_payload,
   output logic        rsp_last
);

   localparam int IdxW = (MAX_LIST_REGS > 1) ? $clog2(MAX_LIST_REGS) : 1;

   // Input register.
   logic                        in_valid_ff, in_valid_in;
   logic [gtsp_pkg::WORD_W-1:0] in_word_ff,  in_word_in;
   logic                        in_end_ff,   in_end_in;

   // Section state.
   gtsp_pkg::phase_type         phase_ff, phase_in;
   logic [gtsp_pkg::LEFT_W-1:0] words_left_ff, words_left_in;
   gtsp_pkg::mode_type          mode_ff, mode_in;
   logic [gtsp_pkg::NREG_W-1:0] reg_count_ff, reg_count_in;
   logic [gtsp_pkg::LIST_W-1:0] reg_list_ff, reg_list_in;
   logic                        end_pending_ff, end_pending_in;

   // Result register.
   logic                        emit_valid_ff, emit_valid_in;
   logic                        emit_kind_ff, emit_kind_in;
   logic                        emit_use_list_ff, emit_use_list_in;
   logic [gtsp_pkg::ADDR_W-1:0] emit_addr_ff, emit_addr_in;
   logic [gtsp_pkg::WORD_W-1:0] emit_word_ff, emit_word_in;
   logic [gtsp_pkg::LIST_W-1:0] emit_list_ff, emit_list_in;
   logic [IdxW-1:0]             emit_idx_ff, emit_idx_in;
   logic [IdxW-1:0]             emit_last_idx_ff, emit_last_idx_in;

   logic emit_is_last, emit_done, emit_free, load;
   logic [gtsp_pkg::WORD_W-1:0]  list_ext;
   logic [3:0]                   list_nibble;

   logic [gtsp_pkg::NLOOP_W-1:0] tag_nloop;
   logic [gtsp_pkg::NREG_W-1:0]  tag_nreg;
   gtsp_pkg::mode_type           tag_mode;
   logic [gtsp_pkg::LEFT_W-1:0]  tag_len;
   logic [gtsp_pkg::LEFT_W-1:0]  left_dec;
   logic [gtsp_pkg::NREG_W-1:0]  clamp_cnt;

   assign emit_is_last = (emit_idx_ff == emit_last_idx_ff);
   assign emit_done    = emit_valid_ff && rsp_ready && emit_is_last;
   assign emit_free    = !emit_valid_ff || emit_done;
   assign load         = in_valid_ff && emit_free;
   assign req_ready    = !in_valid_ff || load;

   // Nibbles past the ninth list entry fall into the zero padding.
   assign list_ext    = {{(gtsp_pkg::WORD_W - gtsp_pkg::LIST_W){1'b0}}, emit_list_ff};
   assign list_nibble = list_ext[{emit_idx_ff, 2'b00} +: 4];

   assign rsp_valid    = emit_valid_ff;
   assign rsp_kind     = emit_kind_ff;
   assign rsp_payload  = emit_word_ff;
   assign rsp_last     = emit_is_last;
   assign rsp_reg_addr = emit_use_list_ff ? {3'b000, list_nibble} : emit_addr_ff;

   // Tag decode.
   assign tag_nloop = in_word_ff[14:0];
   assign tag_nreg  = (in_word_ff[23:18] == '0) ? 6'd1 : in_word_ff[23:18];
   assign tag_mode  = in_word_ff[17:16];
   assign tag_len   = (tag_mode == gtsp_pkg::MODE_IMAGE)
                      ? gtsp_pkg::LEFT_W'(tag_nloop) * gtsp_pkg::LEFT_W'(tag_nreg)
                      : gtsp_pkg::LEFT_W'(tag_nloop);
   assign left_dec  = (words_left_ff != '0) ? words_left_ff - 1'b1 : words_left_ff;
   assign clamp_cnt = (reg_count_ff > 6'(MAX_LIST_REGS)) ? 6'(MAX_LIST_REGS)
                                                          : reg_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         emit_valid_ff  <= 1'b0;
         phase_ff       <= gtsp_pkg::PH_TAG;
         words_left_ff  <= '0;
         mode_ff        <= gtsp_pkg::MODE_LIST;
         reg_count_ff   <= '0;
         reg_list_ff    <= '0;
         end_pending_ff <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         emit_valid_ff  <= emit_valid_in;
         phase_ff       <= phase_in;
         words_left_ff  <= words_left_in;
         mode_ff        <= mode_in;
         reg_count_ff   <= reg_count_in;
         reg_list_ff    <= reg_list_in;
         end_pending_ff <= end_pending_in;
      end
      in_word_ff       <= in_word_in;
      in_end_ff        <= in_end_in;
      emit_kind_ff     <= emit_kind_in;
      emit_use_list_ff <= emit_use_list_in;
      emit_addr_ff     <= emit_addr_in;
      emit_word_ff     <= emit_word_in;
      emit_list_ff     <= emit_list_in;
      emit_idx_ff      <= emit_idx_in;
      emit_last_idx_ff <= emit_last_idx_in;
   end

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      in_end_in   = in_end_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_word_in  = req_word;
         in_end_in   = req_packet_end;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   // Section state machine and result register load.
   always_comb begin
      phase_in         = phase_ff;
      words_left_in    = words_left_ff;
      mode_in          = mode_ff;
      reg_count_in     = reg_count_ff;
      reg_list_in      = reg_list_ff;
      end_pending_in   = end_pending_ff;
      emit_valid_in    = emit_valid_ff;
      emit_kind_in     = emit_kind_ff;
      emit_use_list_in = emit_use_list_ff;
      emit_addr_in     = emit_addr_ff;
      emit_word_in     = emit_word_ff;
      emit_list_in     = emit_list_ff;
      emit_idx_in      = emit_idx_ff;
      emit_last_idx_in = emit_last_idx_ff;

      if (emit_valid_ff && rsp_ready) begin
         if (emit_is_last) begin
            emit_valid_in = 1'b0;
         end else begin
            emit_idx_in = emit_idx_ff + 1'b1;
         end
      end

      if (load) begin
         unique case (phase_ff)
            gtsp_pkg::PH_DATA: begin
               emit_word_in     = in_word_ff;
               emit_list_in     = reg_list_ff;
               emit_idx_in      = '0;
               emit_last_idx_in = '0;
               emit_kind_in     = gtsp_pkg::KIND_WRITE;
               emit_use_list_in = 1'b0;
               emit_addr_in     = '0;
               case (mode_ff)
                  gtsp_pkg::MODE_LIST: begin
                     emit_valid_in    = 1'b1;
                     emit_use_list_in = 1'b1;
                     emit_last_idx_in = IdxW'(clamp_cnt - 6'd1);
                  end
                  gtsp_pkg::MODE_ONE: begin
                     emit_valid_in = 1'b1;
                     emit_addr_in  = in_word_ff[6:0];
                  end
                  gtsp_pkg::MODE_IMAGE: begin
                     emit_valid_in = 1'b1;
                     emit_kind_in  = gtsp_pkg::KIND_IMAGE;
                  end
                  default: begin
                     emit_valid_in = 1'b0;
                  end
               endcase
               words_left_in = left_dec;
               if (left_dec == '0) begin
                  phase_in = end_pending_ff ? gtsp_pkg::PH_DRAIN : gtsp_pkg::PH_TAG;
               end
            end
            gtsp_pkg::PH_DRAIN: begin
               emit_valid_in = 1'b0;
            end
            default: begin
               // Expecting a tag; an unused phase code behaves the same.
               emit_valid_in  = 1'b0;
               end_pending_in = in_word_ff[15];
               mode_in        = tag_mode;
               reg_count_in   = tag_nreg;
               reg_list_in    = in_word_ff[63:28];
               words_left_in  = tag_len;
               if (tag_len == '0) begin
                  phase_in = in_word_ff[15] ? gtsp_pkg::PH_DRAIN : gtsp_pkg::PH_TAG;
               end else begin
                  phase_in = gtsp_pkg::PH_DATA;
               end
            end
         endcase

         if (in_end_ff) begin
            phase_in       = gtsp_pkg::PH_TAG;
            end_pending_in = 1'b0;
            words_left_in  = '0;
         end
      end
   end

   a_image_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == gtsp_pkg::KIND_IMAGE) |-> rsp_last && (rsp_reg_addr == '0))
      else $error("image data transaction is not a single result with address zero");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      emit_valid_ff |-> (emit_idx_ff <= emit_last_idx_ff))
      else $error("result index ran past the last write of the word");

   a_packet_end: assert property (@(posedge clock) disable iff (reset)
      load && in_end_ff |=> (phase_ff == gtsp_pkg::PH_TAG) && !end_pending_ff
                            && (words_left_ff == '0))
      else $error("packet end did not return the parser to expecting a tag");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      emit_valid_ff && !rsp_ready |-> !load)
      else $error("new word loaded while a result transaction was stalled");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for gif_tag_stream_parser_core: directed packet table, then random
// packets, with every result checked against the table or a behavioral parser. Depends on gtsp_pkg.

module tb_top;

   localparam int LIST_MAX  = 16;
   localparam int CYCLE_CAP = 300000;
   localparam int HOLD_LEN  = 300;

   typedef struct packed {
      logic                        kind;
      logic [gtsp_pkg::ADDR_W-1:0] addr;
      logic [gtsp_pkg::WORD_W-1:0] payload;
      logic                        last;
   } tag_result_type;

   typedef enum logic [1:0] {
      BY_MODEL,
      NO_RESULT,
      ONE_RESULT
   } row_check_type;

   typedef struct packed {
      logic [gtsp_pkg::WORD_W-1:0] word;
      logic                        pend;
      row_check_type               how;
      logic                        kind;
      logic [gtsp_pkg::ADDR_W-1:0] addr;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_word = '0;
   logic        req_packet_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [6:0]  rsp_reg_addr;
   logic [63:0] rsp_payload;
   logic        rsp_last;

   // Parser state as the bench tracks it.
   gtsp_pkg::phase_type         pr_phase = gtsp_pkg::PH_TAG;
   logic [gtsp_pkg::LEFT_W-1:0] pr_left = '0;
   gtsp_pkg::mode_type          pr_mode = gtsp_pkg::MODE_LIST;
   logic [gtsp_pkg::NREG_W-1:0] pr_nreg = '0;
   logic [gtsp_pkg::LIST_W-1:0] pr_list = '0;
   logic                        pr_end = 1'b0;

   tag_result_type due_results[$];
   int          bad_cnt = 0;
   int          item_cnt = 0;
   int          cycle_cnt = 0;
   int          send_idle = 0;
   int          recv_idle = 0;
   logic        hold_go = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_cnt = 0;

   gif_tag_stream_parser_core #(
      .MAX_LIST_REGS(LIST_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .req_packet_end(req_packet_end),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_reg_addr(rsp_reg_addr),
      .rsp_payload(rsp_payload),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_CAP) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [63:0] tag_word(logic [35:0] regs, logic [5:0] nreg,
                                            gtsp_pkg::mode_type m, logic eop,
                                            logic [14:0] nloop);
      return {regs, 4'b0000, nreg, m, eop, nloop};
   endfunction

   function automatic dir_row_type mk_row(logic [63:0] w, logic pend, row_check_type how,
                                          logic kind, logic [6:0] addr);
      dir_row_type r;
      r.word = w;
      r.pend = pend;
      r.how  = how;
      r.kind = kind;
      r.addr = addr;
      return r;
   endfunction

   // Advances the tracked parser state by one accepted word and, when emit is set,
   // queues the results that the word should produce.
   task automatic parse_word(input logic [63:0] w, input logic pend, input bit emit);
      int cnt;
      int prod;
      logic [gtsp_pkg::NREG_W-1:0] nreg;
      logic [3:0] addr;
      if (pr_phase == gtsp_pkg::PH_DATA) begin
         case (pr_mode)
            gtsp_pkg::MODE_LIST: begin
               cnt = (pr_nreg > LIST_MAX) ? LIST_MAX : pr_nreg;
               for (int i = 0; i < cnt; i++) begin
                  // Only nine register numbers fit in the tag; the rest read as zero.
                  addr = (i < 9) ? pr_list[4*i +: 4] : 4'd0;
                  if (emit)
                     due_results.push_back({gtsp_pkg::KIND_WRITE, 3'b000, addr, w,
                                            i == cnt - 1});
               end
            end
            gtsp_pkg::MODE_ONE: begin
               if (emit) due_results.push_back({gtsp_pkg::KIND_WRITE, w[6:0], w, 1'b1});
            end
            gtsp_pkg::MODE_IMAGE: begin
               if (emit) due_results.push_back({gtsp_pkg::KIND_IMAGE, 7'd0, w, 1'b1});
            end
            default: ;
         endcase
         if (pr_left != 0) pr_left = pr_left - 1'b1;
         if (pr_left == 0) pr_phase = pr_end ? gtsp_pkg::PH_DRAIN : gtsp_pkg::PH_TAG;
      end else if (pr_phase != gtsp_pkg::PH_DRAIN) begin
         nreg = (w[23:18] == 0) ? 6'd1 : w[23:18];
         pr_end  = w[15];
         pr_mode = w[17:16];
         pr_nreg = nreg;
         pr_list = w[63:28];
         prod = w[14:0] * nreg;
         pr_left = (pr_mode == gtsp_pkg::MODE_IMAGE) ? prod[gtsp_pkg::LEFT_W-1:0]
                                                     : gtsp_pkg::LEFT_W'(w[14:0]);
         if (pr_left == 0) pr_phase = pr_end ? gtsp_pkg::PH_DRAIN : gtsp_pkg::PH_TAG;
         else pr_phase = gtsp_pkg::PH_DATA;
      end
      if (pend) begin
         pr_phase = gtsp_pkg::PH_TAG;
         pr_end = 1'b0;
         pr_left = '0;
      end
   endtask

   task automatic log_miss(input string what, input tag_result_type want,
                           input tag_result_type got);
      bad_cnt++;
      if (bad_cnt <= 10) begin
         $display("%0t: %s: expected kind %0d addr %0d payload %h last %0d", $realtime, what,
                  want.kind, want.addr, want.payload, want.last);
         $display("%0t: %s: actual   kind %0d addr %0d payload %h last %0d", $realtime, what,
                  got.kind, got.addr, got.payload, got.last);
      end
   endtask

   task automatic offer_word(input logic [63:0] w, input logic pend, input bit emit);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      req_packet_end <= pend;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      item_cnt++;
      parse_word(w, pend, emit);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   // Mostly well-formed packets with random content; some are cut short by an early
   // packet end, and some are plain noise.
   task automatic send_random_packet();
      logic [63:0] words[$];
      logic [63:0] w;
      int nsec, nloop, nreg, len, cut;
      gtsp_pkg::mode_type m;
      logic eop;
      bit stop;
      if ($urandom_range(99) < 12) begin
         repeat ($urandom_range(1, 4)) words.push_back({$urandom, $urandom});
      end else begin
         nsec = $urandom_range(1, 3);
         stop = 0;
         for (int s = 0; s < nsec && !stop; s++) begin
            m = gtsp_pkg::mode_type'($urandom_range(0, 3));
            nloop = ($urandom_range(99) < 70) ? $urandom_range(0, 3) : $urandom_range(4, 12);
            case ($urandom_range(0, 3))
               0, 1: nreg = $urandom_range(0, 3);
               2: nreg = $urandom_range(4, 16);
               default: nreg = $urandom_range(17, 63);
            endcase
            if (m == gtsp_pkg::MODE_IMAGE && nreg > 8) nloop = $urandom_range(0, 1);
            eop = ($urandom_range(99) < 20);
            w = {$urandom, $urandom};
            w = tag_word(w[35:0], 6'(nreg), m, eop, 15'(nloop)) | {36'd0, w[63:60], 24'd0};
            words.push_back(w);
            len = (m == gtsp_pkg::MODE_IMAGE) ? nloop * ((nreg == 0) ? 1 : nreg) : nloop;
            repeat (len) words.push_back({$urandom, $urandom});
            if (eop) begin
               repeat ($urandom_range(0, 2)) words.push_back({$urandom, $urandom});
               stop = 1;
            end
         end
         if ($urandom_range(99) < 10) begin
            cut = $urandom_range(0, words.size() - 1);
            while (words.size() > cut + 1) void'(words.pop_back());
         end
      end
      foreach (words[i]) offer_word(words[i], i == words.size() - 1, 1'b1);
   endtask

   always @(posedge clock) begin
      if (hold_go != hold_seen) begin
         hold_seen <= hold_go;
         hold_cnt <= HOLD_LEN;
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin : check_results
      tag_result_type got;
      tag_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_kind, rsp_reg_addr, rsp_payload, rsp_last};
         if (due_results.size() == 0) begin
            log_miss("unexpected transaction", '0, got);
         end else begin
            want = due_results.pop_front();
            if (got.kind !== want.kind || got.addr !== want.addr ||
                got.payload !== want.payload || got.last !== want.last)
               log_miss("result mismatch", want, got);
         end
      end
   end

   initial begin : stimulus
      dir_row_type dir_rows[$];
      // Plain list section, then the single-register and clamped list cases.
      dir_rows.push_back(mk_row(tag_word(36'h321, 6'd3, gtsp_pkg::MODE_LIST, 1'b0, 15'd2),
                                1'b0, NO_RESULT, gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row(64'h0, 1'b0, BY_MODEL, gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row('1, 1'b0, BY_MODEL, gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row(tag_word(36'hF, 6'd0, gtsp_pkg::MODE_LIST, 1'b0, 15'd1),
                                1'b0, NO_RESULT, gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row(64'h0123_4567_89AB_CDEF, 1'b0, ONE_RESULT,
                                gtsp_pkg::KIND_WRITE, 7'd15));
      dir_rows.push_back(mk_row(tag_word(36'h987654321, 6'd63, gtsp_pkg::MODE_LIST, 1'b0,
                                         15'd1),
                                1'b0, NO_RESULT, gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row(64'hA5A5_5A5A_FFFF_0000, 1'b0, BY_MODEL,
                                gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row(tag_word(36'h0, 6'd17, gtsp_pkg::MODE_LIST, 1'b0, 15'd1),
                                1'b0, NO_RESULT, gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row(64'h8000_0000_0000_0001, 1'b0, BY_MODEL,
                                gtsp_pkg::KIND_WRITE, 7'd0));
      // Addressed writes, image pass-through and a skipped section.
      dir_rows.push_back(mk_row(tag_word('1, 6'd1, gtsp_pkg::MODE_ONE, 1'b0, 15'd2), 1'b0,
                                NO_RESULT, gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row('1, 1'b0, ONE_RESULT, gtsp_pkg::KIND_WRITE, 7'h7F));
      dir_rows.push_back(mk_row(64'h0, 1'b0, ONE_RESULT, gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row(tag_word(36'h0, 6'd3, gtsp_pkg::MODE_IMAGE, 1'b0, 15'd1),
                                1'b0, NO_RESULT, gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row(64'h1111_2222_3333_4444, 1'b0, BY_MODEL,
                                gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row('1, 1'b0, BY_MODEL, gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row(64'hDEAD_BEEF_0000_0000, 1'b0, BY_MODEL,
                                gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row(tag_word(36'h0, 6'd0, gtsp_pkg::MODE_SKIP, 1'b0, 15'd2),
                                1'b0, NO_RESULT, gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row('1, 1'b0, NO_RESULT, gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row(64'h1234, 1'b0, NO_RESULT, gtsp_pkg::KIND_WRITE, 7'd0));
      // An empty section with the end flag drains the rest of the packet.
      dir_rows.push_back(mk_row(tag_word(36'h0, 6'd0, gtsp_pkg::MODE_ONE, 1'b1, 15'd0),
                                1'b0, NO_RESULT, gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row('1, 1'b0, NO_RESULT, gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row(64'h5, 1'b1, NO_RESULT, gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row(tag_word(36'h0, 6'd0, gtsp_pkg::MODE_ONE, 1'b1, 15'd1),
                                1'b0, NO_RESULT, gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row(64'h55, 1'b0, ONE_RESULT, gtsp_pkg::KIND_WRITE, 7'h55));
      dir_rows.push_back(mk_row('1, 1'b0, NO_RESULT, gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row(64'h0, 1'b1, NO_RESULT, gtsp_pkg::KIND_WRITE, 7'd0));
      // Packet end in the middle of a section, then an all-ones tag.
      dir_rows.push_back(mk_row(tag_word(36'h21, 6'd2, gtsp_pkg::MODE_LIST, 1'b0, 15'd5),
                                1'b0, NO_RESULT, gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row(64'hFEDC_BA98_7654_3210, 1'b1, BY_MODEL,
                                gtsp_pkg::KIND_WRITE, 7'd0));
      dir_rows.push_back(mk_row('1, 1'b1, NO_RESULT, gtsp_pkg::KIND_WRITE, 7'd0));

      send_idle = 17;
      recv_idle = 72;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         offer_word(dir_rows[i].word, dir_rows[i].pend, dir_rows[i].how == BY_MODEL);
         if (dir_rows[i].how == ONE_RESULT)
            due_results.push_back({dir_rows[i].kind, dir_rows[i].addr, dir_rows[i].word, 1'b1});
      end

      while (item_cnt < 130) send_random_packet();
      wait_drained();

      send_idle = 72;
      recv_idle = 17;
      while (item_cnt < 260) send_random_packet();
      wait_drained();

      // No idling, but the receiver first holds off long enough for the input to back up.
      send_idle = 0;
      recv_idle = 0;
      hold_go <= ~hold_go;
      while (item_cnt < 380) send_random_packet();
      wait_drained();

      repeat (40) @(posedge clock);
      if (bad_cnt == 0 && due_results.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
